[src/tks_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the top-k index selector.
// No dependencies; used by tks_cell and top_k_index_selector.
package tks_pkg;

  localparam int VAL_W  = 16;
  localparam int IDX_W  = 16;
  localparam int RANK_W = 4;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] TOP_COUNT_RESET = 5'd10;

  // one kept (value, index) pair
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_CLEAR  = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } cell_ctrl_t;

endpackage

[src/tks_cell.sv]
`timescale 1ns / 1ps
// One compare-and-shift cell of the sorted top-k chain.
// Depends on tks_pkg.
module tks_cell
  import tks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     prev_ent,    // higher-ranked neighbour
  input  logic       prev_below,  // neighbour is giving way to the new item
  input  entry_t     next_ent,    // lower-ranked neighbour
  output entry_t     ent_o,
  output logic       below_o
);

  entry_t ent_r, ent_nxt;

  // new item has the larger index, so it wins ties
  assign below_o = !ent_r.valid || (ent_r.value <= ctrl.value);
  assign ent_o   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (prev_below) begin
          ent_nxt = prev_ent;
        end else if (below_o) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.value = ctrl.value;
          ent_nxt.index = ctrl.index;
        end
      end
      CELL_SHIFT: ent_nxt = next_ent;
      CELL_CLEAR: ent_nxt.valid = 1'b0;
      default:    ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r.value <= ent_nxt.value;
    ent_r.index <= ent_nxt.index;
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

endmodule

[src/top_k_index_selector.sv]
`timescale 1ns / 1ps
// Streaming top-k selector: chain of tks_cell, row counter, drain control.
// Depends on tks_pkg and tks_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in_     | in        | in_valid/in_stall  | probability, row_end
//  out_    | out       | out_valid/out_stall| word_index, rank, word_probability,
//          |           |                    | last_of_list
//  cfg_    | in        | cfg_valid/cfg_ready| top_count
//
// One item per cycle while a row streams: every cell compares against the
// new item and shifts in the same cycle. After a row end the chain drains
// one result per cycle through cell 0 unless the output stalls, and the
// block stalls input until the drain ends.
// Synchronous reset empties the chain at once; no clearing pass.
module top_k_index_selector
  import tks_pkg::*;
#(
  parameter int MAX_TOP    = 16,
  parameter int VOCAB_SIZE = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VAL_W-1:0]  in_probability,
  input  logic              in_row_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_word_index,
  output logic [RANK_W-1:0] out_rank,
  output logic [VAL_W-1:0]  out_word_probability,
  output logic              out_last_of_list,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_top_count
);

  localparam int CW    = $clog2(VOCAB_SIZE + 1);
  localparam int RW    = $clog2(MAX_TOP + 1);
  localparam int CMP_W = (RW > CFG_W) ? RW : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  top_count_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     rank_r, rank_nxt;
  logic [RW-1:0]     n_eff;
  logic [CMP_W-1:0]  tc_ext;
  cell_ctrl_t        ctrl;
  entry_t            ents [MAX_TOP+1];
  logic              belows [MAX_TOP];
  logic              in_acc, in_range, out_load, is_last;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = (col_r < CW'(VOCAB_SIZE));

  // top_count clamped to 1..MAX_TOP
  assign tc_ext = CMP_W'(top_count_r);
  always_comb begin
    if (tc_ext == '0) begin
      n_eff = RW'(1);
    end else if (tc_ext > CMP_W'(MAX_TOP)) begin
      n_eff = RW'(MAX_TOP);
    end else begin
      n_eff = RW'(tc_ext);
    end
  end

  // sentinel past the last cell
  assign ents[MAX_TOP] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TOP; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        tks_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctrl      (ctrl),
          .prev_ent  (entry_t'('0)),
          .prev_below(1'b0),
          .next_ent  (ents[gi+1]),
          .ent_o     (ents[gi]),
          .below_o   (belows[gi])
        );
      end else begin : g_body
        tks_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctrl      (ctrl),
          .prev_ent  (ents[gi-1]),
          .prev_below(belows[gi-1]),
          .next_ent  (ents[gi+1]),
          .ent_o     (ents[gi]),
          .below_o   (belows[gi])
        );
      end
    end
  endgenerate

  assign out_load = (state_r == ST_DRAIN) && ents[0].valid && (!out_valid_r || !out_stall);
  assign is_last  = ((rank_r + RW'(1)) == n_eff) || !ents[1].valid;

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    rank_nxt   = rank_r;
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_probability;
    ctrl.index = IDX_W'(col_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_range) begin
            ctrl.op = CELL_INSERT;
            col_nxt = col_r + CW'(1);
          end
          if (in_row_end) begin
            col_nxt   = '0;
            rank_nxt  = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!ents[0].valid) begin
          // nothing held: just end the row
          ctrl.op   = CELL_CLEAR;
          state_nxt = ST_IDLE;
        end else if (out_load) begin
          if (is_last) begin
            ctrl.op   = CELL_CLEAR;
            state_nxt = ST_IDLE;
          end else begin
            ctrl.op  = CELL_SHIFT;
            rank_nxt = rank_r + RW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_count_r <= TOP_COUNT_RESET;
      col_r       <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      rank_r  <= rank_nxt;
      if (cfg_valid && cfg_ready) begin
        top_count_r <= cfg_top_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= ents[0].index;
      out_val_r  <= ents[0].value;
      out_rank_r <= RANK_W'(rank_r);
      out_last_r <= is_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_word_index       = out_idx_r;
  assign out_rank             = out_rank_r;
  assign out_word_probability = out_val_r;
  assign out_last_of_list     = out_last_r;

endmodule

[sim/tb_top_k_index_selector.sv]
`timescale 1ns / 1ps
// Testbench for top_k_index_selector: rows of probabilities in, ranked picks checked
// against a top-k predictor held in a small scoreboard class. Depends on tks_pkg.
module tb_top_k_index_selector
  import tks_pkg::*;
();

  localparam int KEEP_DEPTH    = 16;
  localparam int VOCAB         = 65536;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 90;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 56;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  word_probability;
    logic              last_of_list;
  } pick_t;

  class topk_scoreboard;
    logic [VAL_W-1:0] kept_val[KEEP_DEPTH];
    logic [IDX_W-1:0] kept_idx[KEEP_DEPTH];
    int unsigned      kept_n;
    int unsigned      column;
    logic [CFG_W-1:0] top_count;
    pick_t            picks_due[$];
    int               errors;

    function void clear_row();
      for (int i = 0; i < KEEP_DEPTH; i++) begin
        kept_val[i] = '0;
        kept_idx[i] = '0;
      end
      kept_n = 0;
      column = 0;
    endfunction

    function void reset();
      top_count = TOP_COUNT_RESET;
      picks_due.delete();
      errors = 0;
      clear_row();
    endfunction

    function void set_top_count(logic [CFG_W-1:0] v);
      top_count = v;
    endfunction

    function int pending();
      return picks_due.size();
    endfunction

    function void queue_pick(pick_t pk);
      picks_due = {picks_due, pk};
    endfunction

    // note an accepted item; on a row end, queue the ranked picks
    function void note_item(logic [VAL_W-1:0] p, logic re);
      int unsigned pos, j, n, emit;
      pick_t pk;
      if (column < VOCAB) begin
        pos = 0;
        // newest index wins ties, so it goes above any equal value
        while (pos < kept_n && kept_val[pos] > p) pos++;
        if (pos < KEEP_DEPTH) begin
          j = (kept_n < KEEP_DEPTH) ? kept_n : KEEP_DEPTH - 1;
          while (j > pos) begin
            kept_val[j] = kept_val[j-1];
            kept_idx[j] = kept_idx[j-1];
            j--;
          end
          kept_val[pos] = p;
          kept_idx[pos] = IDX_W'(column);
          if (kept_n < KEEP_DEPTH) kept_n++;
        end
        column++;
      end
      if (!re) return;
      n = top_count;
      if (n < 1) n = 1;
      if (n > KEEP_DEPTH) n = KEEP_DEPTH;
      emit = (kept_n < n) ? kept_n : n;
      for (int unsigned k = 0; k < emit; k++) begin
        pk.word_index       = kept_idx[k];
        pk.rank             = RANK_W'(k);
        pk.word_probability = kept_val[k];
        pk.last_of_list     = (k + 1 == emit);
        queue_pick(pk);
      end
      clear_row();
    endfunction

    function void check_result(pick_t got);
      pick_t want;
      if (picks_due.size() == 0) begin
        $error("result with nothing expected: word_index %0d rank %0d",
               got.word_index, got.rank);
        errors++;
        return;
      end
      want = picks_due.pop_front();
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, got %0d", want.rank, got.rank);
        errors++;
      end
      if (got.word_probability !== want.word_probability) begin
        $error("word_probability: expected %0d, got %0d",
               want.word_probability, got.word_probability);
        errors++;
      end
      if (got.last_of_list !== want.last_of_list) begin
        $error("last_of_list: expected %0d, got %0d", want.last_of_list, got.last_of_list);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [VAL_W-1:0]  in_probability = '0;
  logic              in_row_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_word_index;
  logic [RANK_W-1:0] out_rank;
  logic [VAL_W-1:0]  out_word_probability;
  logic              out_last_of_list;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_top_count = '0;

  topk_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycles         = 0;

  top_k_index_selector #(
    .MAX_TOP    (KEEP_DEPTH),
    .VOCAB_SIZE (VOCAB)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_probability       (in_probability),
    .in_row_end           (in_row_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_word_index       (out_word_index),
    .out_rank             (out_rank),
    .out_word_probability (out_word_probability),
    .out_last_of_list     (out_last_of_list),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_top_count        (cfg_top_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top_k_index_selector: done, errors");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_word_index, out_rank, out_word_probability, out_last_of_list});
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  task automatic send_item(input logic [VAL_W-1:0] p, input logic re);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_probability <= p;
    in_row_end     <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(p, re);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input int style);
    case (style)
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(3));          // heavy ties
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      default: return {8'hFF, 8'($urandom)};
    endcase
  endfunction

  task automatic send_row(input int len, input int style);
    for (int i = 0; i < len; i++) send_item(pick_value(style), i == len - 1);
  endtask

  // idle the sender until every pick has come out, then let the drain settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_top_count(input logic [CFG_W-1:0] v);
    cfg_valid     <= 1'b1;
    cfg_top_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_top_count(v);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg[NUM_PHASES];
    logic [VAL_W-1:0] mixed_row[12];
    int sent, len, r;
    bit paused;

    phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd10, 5'd3};
    phase_cfg[NUM_PHASES-1] = CFG_W'($urandom_range(3, 15));
    mixed_row = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h0005,
                  16'h0005, 16'h0005, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
    sb = new();
    sb.reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-word rows, a mixed row under the reset count, then zero
    // and oversized counts
    set_idling(0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b1);
    foreach (mixed_row[i]) send_item(mixed_row[i], i == 11);
    wait_drained();
    write_top_count(5'd0);
    send_row(3, 2);
    wait_drained();
    write_top_count(5'd31);
    send_row(5, 1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_top_count(phase_cfg[ph]);
      set_idling(ph % 4);
      if (ph == 4) hold_requests <= hold_requests + 1;
      sent   = 0;
      paused = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1;
        end
        r = $urandom_range(9);
        if (r < 6)      len = $urandom_range(1, 20);
        else if (r < 8) len = $urandom_range(17, 40);   // overflows the kept list
        else            len = $urandom_range(1, 3);
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        send_row(len, $urandom_range(3));
        sent += len;
      end
    end

    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top_k_index_selector: done, clean");
    else
      $display("tb_top_k_index_selector: done, errors");
    $finish;
  end

endmodule
